>>> hw/rtl/blab_pkg.sv
// Shared types, constants and helpers of the line/arc blend evaluator.
package blab_pkg;

  localparam int unsigned S_W     = 17;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned CFG_W   = 60;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int PI_Q28      = 843314857;
  localparam int HALF_PI_Q28 = 421657428;
  localparam int TWO_PI_Q28  = 1686629713;
  localparam int GAIN_Q30    = 652032874;

  localparam int unsigned XY_W = 34;
  localparam int unsigned Z_W  = 33;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef enum logic [IDX_W-1:0] {
    CFG_LINE_START  = 3'd0,
    CFG_JOINT_POINT = 3'd1,
    CFG_ARC_CENTER  = 3'd2,
    CFG_ARC_AXIS    = 3'd3,
    CFG_ARC_ANGLE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic           vld;
    logic [S_W-1:0] s;
  } item_t;

  typedef struct packed {
    logic signed [26:0] tem;
    logic signed [26:0] j1;
    logic signed [26:0] k5;
    logic signed [29:0] ph1;
    logic signed [29:0] ph2;
    logic signed [37:0] k2;
  } scal_t;

  // round half up, then drop k fraction bits
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                 input int unsigned k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

endpackage

>>> hw/rtl/bezier_line_arc_blend_core.sv
// Top level of the line-to-arc blend evaluator: registers, geometry, front and back.
//
//  channel  | ports                                   | flow
//  ---------+-----------------------------------------+--------------------------
//  request  | start, busy, blend_param_i              | taken when start & !busy
//  result   | result_valid_o, pos/vel/acc_*_o, sat.   | one-cycle strobe
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i        | written when cfg_we_i
//
// One request per cycle while busy is low; each result passes the queue, the power,
// reduction and fold stages, the CORDIC pipeline and the coefficient, sum and saturation stages.
// Reset clears the configuration registers, the queue pointers and all valid flags.
// The result side cannot stall; busy rises only when the request queue is full.
module bezier_line_arc_blend_core import blab_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 20,
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [S_W-1:0]          blend_param_i,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  output logic                    result_valid_o,
  output logic signed [OUT_W-1:0] pos_x_o,
  output logic signed [OUT_W-1:0] pos_y_o,
  output logic signed [OUT_W-1:0] pos_z_o,
  output logic signed [OUT_W-1:0] vel_x_o,
  output logic signed [OUT_W-1:0] vel_y_o,
  output logic signed [OUT_W-1:0] vel_z_o,
  output logic signed [OUT_W-1:0] acc_x_o,
  output logic signed [OUT_W-1:0] acc_y_o,
  output logic signed [OUT_W-1:0] acc_z_o,
  output logic                    saturated_o
);

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned D_W     = W + 1;
  localparam int unsigned B_W     = W + 2;
  localparam int unsigned RY_W    = W + 4;
  localparam int unsigned XP_W    = 2 * W + 1;
  localparam int unsigned LATENCY = CORDIC_STEPS + 16;

  logic [CFG_W-1:0] ls_q, jp_q, ac_q, ax_q;
  logic signed [ANGLE_W-1:0] ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q  <= '0;
      jp_q  <= '0;
      ac_q  <= '0;
      ax_q  <= '0;
      ang_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE_START:  ls_q  <= cfg_wdata_i;
        CFG_JOINT_POINT: jp_q  <= cfg_wdata_i;
        CFG_ARC_CENTER:  ac_q  <= cfg_wdata_i;
        CFG_ARC_AXIS:    ax_q  <= cfg_wdata_i;
        CFG_ARC_ANGLE:   ang_q <= cfg_wdata_i[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [63:0] ls64, jp64, ac64, ax64;
  logic signed [W-1:0] p0 [3], p1 [3], cc [3], ax [3];

  assign ls64 = 64'(ls_q);
  assign jp64 = 64'(jp_q);
  assign ac64 = 64'(ac_q);
  assign ax64 = 64'(ax_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i] = ls64[i*W +: W];
      p1[i] = jp64[i*W +: W];
      cc[i] = ac64[i*W +: W];
      ax[i] = ax64[i*W +: W];
    end
  end

  logic signed [D_W-1:0]  d_q [3], rx_q [3];
  logic signed [B_W-1:0]  base_q [3];
  logic signed [XP_W-1:0] xp_q [6];
  logic signed [RY_W-1:0] ry_q [3];
  logic signed [24:0]     th20_q;
  logic signed [49:0]     th2p_q;
  logic [26:0]            th2_q;

  // derived geometry settles in registered stages after a write
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]    <= D_W'(p1[i]) - D_W'(p0[i]);
      rx_q[i]   <= D_W'(p1[i]) - D_W'(cc[i]);
      base_q[i] <= B_W'(p0[i]) + B_W'(cc[i]) - B_W'(p1[i]);
    end
    xp_q[0] <= XP_W'(ax[1]) * XP_W'(rx_q[2]);
    xp_q[1] <= XP_W'(ax[2]) * XP_W'(rx_q[1]);
    xp_q[2] <= XP_W'(ax[2]) * XP_W'(rx_q[0]);
    xp_q[3] <= XP_W'(ax[0]) * XP_W'(rx_q[2]);
    xp_q[4] <= XP_W'(ax[0]) * XP_W'(rx_q[1]);
    xp_q[5] <= XP_W'(ax[1]) * XP_W'(rx_q[0]);
    ry_q[0] <= RY_W'(rnd_sh(64'(xp_q[0]) - 64'(xp_q[1]), W - 2));
    ry_q[1] <= RY_W'(rnd_sh(64'(xp_q[2]) - 64'(xp_q[3]), W - 2));
    ry_q[2] <= RY_W'(rnd_sh(64'(xp_q[4]) - 64'(xp_q[5]), W - 2));
    th20_q  <= 25'(rnd_sh(64'(ang_q), 8));
    th2p_q  <= 50'(th20_q) * 50'(th20_q);
    th2_q   <= 27'(rnd_sh(64'(th2p_q), 20));
  end

  item_t item;

  blab_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .s_i    (blend_param_i),
    .item_o (item)
  );

  logic signed [OUT_W-1:0] res [9];

  blab_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item),
    .d_i   (d_q),
    .rx_i  (rx_q),
    .ry_i  (ry_q),
    .base_i(base_q),
    .th_i  (ang_q),
    .th20_i(th20_q),
    .th2_i (th2_q),
    .vld_o (result_valid_o),
    .res_o (res),
    .sat_o (saturated_o)
  );

  assign pos_x_o = res[0];
  assign pos_y_o = res[1];
  assign pos_z_o = res[2];
  assign vel_x_o = res[3];
  assign vel_y_o = res[4];
  assign vel_z_o = res[5];
  assign acc_x_o = res[6];
  assign acc_y_o = res[7];
  assign acc_z_o = res[8];

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(LATENCY) result_valid_o)
    else $error("request gave no result at the expected cycle");

  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_sat_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |-> result_valid_o)
    else $error("saturation flag outside a result");
`endif

endmodule

>>> hw/rtl/blab_front.sv
// Request front end: accepts blend parameters into a short queue.
module blab_front import blab_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [S_W-1:0] s_i,
  output item_t          item_o
);

  logic [S_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0] cnt_q, cnt_d;
  logic push, pop;

  assign busy_o = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push   = start_i && !busy_o;
  assign pop    = (cnt_q != '0);
  assign cnt_d  = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);

  assign item_o.vld = pop;
  assign item_o.s   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= s_i;
  end

endmodule

>>> hw/rtl/blab_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage.
module blab_cordic import blab_pkg::*; #(
  parameter int unsigned STEPS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic signed [Z_W-1:0]  z_i,
  input  logic                   neg_i,
  output logic                   vld_o,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [XY_W-1:0] y_o,
  output logic                   neg_o
);

  logic signed [XY_W-1:0] x_q [STEPS];
  logic signed [XY_W-1:0] y_q [STEPS];
  logic signed [Z_W-1:0]  z_q [STEPS];
  logic [STEPS-1:0]       neg_q;
  logic [STEPS-1:0]       v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[STEPS-2:0], vld_i};
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_it
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  zs;
    logic                   ns;
    if (k == 0) begin : g_first
      assign xs = XY_W'(GAIN_Q30);
      assign ys = '0;
      assign zs = z_i;
      assign ns = neg_i;
    end else begin : g_next
      assign xs = x_q[k-1];
      assign ys = y_q[k-1];
      assign zs = z_q[k-1];
      assign ns = neg_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (zs >= 0) begin
        x_q[k] <= xs - (ys >>> k);
        y_q[k] <= ys + (xs >>> k);
        z_q[k] <= zs - $signed(Z_W'(ATAN_Q30[k]));
      end else begin
        x_q[k] <= xs + (ys >>> k);
        y_q[k] <= ys - (xs >>> k);
        z_q[k] <= zs + $signed(Z_W'(ATAN_Q30[k]));
      end
      neg_q[k] <= ns;
    end
  end

  assign vld_o = v_q[STEPS-1];
  assign x_o   = x_q[STEPS-1];
  assign y_o   = y_q[STEPS-1];
  assign neg_o = neg_q[STEPS-1];

endmodule

>>> hw/rtl/blab_back.sv
// Evaluation pipeline: s powers, phase reduction, CORDIC, blend sums, saturation.
module blab_back import blab_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 20,
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  item_t                       item_i,
  input  logic signed [COORD_WIDTH:0]   d_i    [3],
  input  logic signed [COORD_WIDTH:0]   rx_i   [3],
  input  logic signed [COORD_WIDTH+3:0] ry_i   [3],
  input  logic signed [COORD_WIDTH+1:0] base_i [3],
  input  logic signed [ANGLE_W-1:0]   th_i,
  input  logic signed [24:0]          th20_i,
  input  logic [26:0]                 th2_i,
  output logic                        vld_o,
  output logic signed [OUT_W-1:0]     res_o  [9],
  output logic                        sat_o
);

  localparam int unsigned N = CORDIC_STEPS;
  localparam logic [35:0] TP8 = 36'(TWO_PI_Q28) << 3;
  localparam logic [35:0] TP4 = 36'(TWO_PI_Q28) << 2;
  localparam logic [35:0] TP2 = 36'(TWO_PI_Q28) << 1;
  localparam logic [35:0] TP1 = 36'(TWO_PI_Q28);
  localparam logic signed [32:0] PI_R  = 33'(PI_Q28);
  localparam logic signed [32:0] HPI_R = 33'(HALF_PI_Q28);
  localparam logic signed [32:0] TPI_R = 33'(TWO_PI_Q28);

  logic [8:0] pv_q;
  logic [5:0] rv_q;

  logic [S_W-1:0] sa_q, sb_q, sc_q, sd_q, se_q, sf_q;
  logic [33:0] s2b_q;
  logic [21:0] s2c_q, s2d_q, s2e_q, s2f_q;
  logic [50:0] s3c_q;
  logic [22:0] s3d_q, s3e_q, s3f_q;
  logic [39:0] s4p_q;
  logic signed [55:0] php_q;
  logic [24:0] s4f_q;
  logic signed [35:0] phf_q;

  logic [35:0] m0, m1, m2, m3, m4;
  logic [35:0] magg_q;
  logic psgng_q, psgnh_q;
  logic signed [26:0] s1x, s2x, s3x;
  logic signed [26:0] temg_q, j1g_q, k5g_q;
  logic signed [49:0] ph1p_q, ph2p_q;
  logic [55:0] k2p_q;
  logic [30:0] magh_q;
  scal_t sch_q, sci_q;

  logic signed [32:0] r;
  logic fneg;
  logic signed [Z_W-1:0] zi_q;
  logic negi_q;

  logic c_vld, c_neg;
  logic signed [XY_W-1:0] c_x, c_y, xn, yn;
  scal_t sc_dly_q [N];

  scal_t sc1_q, sc2_q, sc3_q;
  logic signed [23:0] co1_q, si1_q, co2_q, si2_q, co3_q, si3_q;
  logic signed [53:0] p_ph1co_q, p_ph1si_q, p_ph2co_q, p_ph2si_q;
  logic signed [61:0] p_k2si_q, p_k2co_q;
  logic signed [35:0] j2_q, j3_q;
  logic signed [43:0] k3_q, k4_q;

  logic signed [63:0] prd_q [9][4];
  logic signed [63:0] acc_q [9];
  logic signed [OUT_W-1:0] res_q [9];
  logic sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      rv_q <= '0;
    end else begin
      pv_q <= {pv_q[7:0], item_i.vld};
      rv_q <= {rv_q[4:0], c_vld};
    end
  end

  // s powers and phase product
  always_ff @(posedge clk_i) begin
    sa_q  <= item_i.s;
    sb_q  <= sa_q;
    s2b_q <= 34'(sa_q) * 34'(sa_q);
    sc_q  <= sb_q;
    s2c_q <= 22'((s2b_q + 34'd2048) >> 12);
    s3c_q <= 51'(s2b_q) * 51'(sb_q);
    sd_q  <= sc_q;
    s2d_q <= s2c_q;
    s3d_q <= 23'((s3c_q + 51'd134217728) >> 28);
    se_q  <= sd_q;
    s2e_q <= s2d_q;
    s3e_q <= s3d_q;
    s4p_q <= 40'(s3d_q) * 40'(sd_q);
    php_q <= 56'($signed({1'b0, s3d_q})) * 56'(th_i);
    sf_q  <= se_q;
    s2f_q <= s2e_q;
    s3f_q <= s3e_q;
    s4f_q <= 25'((s4p_q + 40'd32768) >> 16);
    phf_q <= 36'(rnd_sh(64'(php_q), 20));
  end

  // reduction of the phase modulo two pi, coefficient products
  assign s1x = 27'({sf_q, 4'b0000});
  assign s2x = 27'(s2f_q);
  assign s3x = 27'(s3f_q);

  always_comb begin
    m0 = phf_q[35] ? 36'(~phf_q + 36'sd1) : 36'(phf_q);
    m1 = (m0 >= TP8) ? m0 - TP8 : m0;
    m2 = (m1 >= TP4) ? m1 - TP4 : m1;
    m3 = (magg_q >= TP2) ? magg_q - TP2 : magg_q;
    m4 = (m3 >= TP1) ? m3 - TP1 : m3;
  end

  always_ff @(posedge clk_i) begin
    magg_q  <= m2;
    psgng_q <= phf_q[35];
    temg_q  <= s3x - 27'sd3 * s2x + 27'sd3 * s1x;
    j1g_q   <= 27'sd3 * s2x - 27'sd6 * s1x + 27'sd3145728;
    k5g_q   <= 27'sd6 * s1x - 27'sd6291456;
    ph1p_q  <= (50'(s2x) * 50'sd3) * 50'(th20_i);
    ph2p_q  <= (50'(s1x) * 50'sd6) * 50'(th20_i);
    k2p_q   <= (56'(s4f_q) * 56'd9) * 56'(th2_i);

    magh_q    <= m4[30:0];
    psgnh_q   <= psgng_q;
    sch_q.tem <= temg_q;
    sch_q.j1  <= j1g_q;
    sch_q.k5  <= k5g_q;
    sch_q.ph1 <= 30'(rnd_sh(64'(ph1p_q), 20));
    sch_q.ph2 <= 30'(rnd_sh(64'(ph2p_q), 20));
    sch_q.k2  <= 38'(rnd_sh(64'(k2p_q), 20));
  end

  // fold into the right half plane
  always_comb begin
    r = psgnh_q ? -$signed({2'b00, magh_q}) : $signed({2'b00, magh_q});
    fneg = 1'b0;
    if (r > PI_R) r = r - TPI_R;
    if (r < -PI_R) r = r + TPI_R;
    if (r > HPI_R) begin
      r = r - PI_R;
      fneg = 1'b1;
    end
    if (r < -HPI_R) begin
      r = r + PI_R;
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    zi_q   <= r <<< 2;
    negi_q <= fneg;
    sci_q  <= sch_q;
    sc_dly_q[0] <= sci_q;
    for (int k = 1; k < N; k++) sc_dly_q[k] <= sc_dly_q[k-1];
  end

  blab_cordic #(
    .STEPS(N)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (pv_q[8]),
    .z_i   (zi_q),
    .neg_i (negi_q),
    .vld_o (c_vld),
    .x_o   (c_x),
    .y_o   (c_y),
    .neg_o (c_neg)
  );

  assign xn = c_neg ? -c_x : c_x;
  assign yn = c_neg ? -c_y : c_y;

  // derivative coefficients
  always_ff @(posedge clk_i) begin
    co1_q <= 24'(rnd_sh(64'(xn), 10));
    si1_q <= 24'(rnd_sh(64'(yn), 10));
    sc1_q <= sc_dly_q[N-1];

    co2_q     <= co1_q;
    si2_q     <= si1_q;
    sc2_q     <= sc1_q;
    p_ph1co_q <= 54'(sc1_q.ph1) * 54'(co1_q);
    p_ph1si_q <= 54'(sc1_q.ph1) * 54'(si1_q);
    p_ph2co_q <= 54'(sc1_q.ph2) * 54'(co1_q);
    p_ph2si_q <= 54'(sc1_q.ph2) * 54'(si1_q);
    p_k2si_q  <= 62'(sc1_q.k2) * 62'(si1_q);
    p_k2co_q  <= 62'(sc1_q.k2) * 62'(co1_q);

    co3_q <= co2_q;
    si3_q <= si2_q;
    sc3_q <= sc2_q;
    j2_q  <= 36'(rnd_sh(64'(p_ph1co_q), 20));
    j3_q  <= 36'(-rnd_sh(64'(p_ph1si_q), 20));
    k3_q  <= 44'(rnd_sh(64'(p_ph2co_q) - 64'(p_k2si_q), 20));
    k4_q  <= 44'(rnd_sh(-64'(p_k2co_q) - 64'(p_ph2si_q), 20));
  end

  // blend terms per axis
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      prd_q[i][0]   <= 64'(base_i[i]) <<< 20;
      prd_q[i][1]   <= 64'(sc3_q.tem) * 64'(d_i[i]);
      prd_q[i][2]   <= 64'(si3_q) * 64'(ry_i[i]);
      prd_q[i][3]   <= 64'(co3_q) * 64'(rx_i[i]);
      prd_q[3+i][0] <= '0;
      prd_q[3+i][1] <= 64'(sc3_q.j1) * 64'(d_i[i]);
      prd_q[3+i][2] <= 64'(j2_q) * 64'(ry_i[i]);
      prd_q[3+i][3] <= 64'(j3_q) * 64'(rx_i[i]);
      prd_q[6+i][0] <= '0;
      prd_q[6+i][1] <= 64'(sc3_q.k5) * 64'(d_i[i]);
      prd_q[6+i][2] <= 64'(k3_q) * 64'(ry_i[i]);
      prd_q[6+i][3] <= 64'(k4_q) * 64'(rx_i[i]);
    end
    for (int n = 0; n < 9; n++) begin
      acc_q[n] <= prd_q[n][0] + prd_q[n][1] + prd_q[n][2] + prd_q[n][3];
    end
  end

  logic signed [OUT_W-1:0] res_d [9];
  logic flag;

  always_comb begin
    logic signed [63:0] rv;
    flag = 1'b0;
    for (int n = 0; n < 9; n++) begin
      rv = rnd_sh(acc_q[n], 20);
      if (rv > 64'sd2147483647) begin
        res_d[n] = 32'sh7fffffff;
        flag     = 1'b1;
      end else if (rv < -64'sd2147483648) begin
        res_d[n] = 32'sh80000000;
        flag     = 1'b1;
      end else begin
        res_d[n] = rv[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else begin
      sat_q <= flag && rv_q[4];
    end
  end

  assign vld_o = rv_q[5];
  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule
